// File: design/cc20_pkg.sv
package cc20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  // Each double round is four half quarter-round steps: column, then diagonal.
  localparam int STEPS  = 4 * DOUBLE_ROUNDS;
  localparam int STEP_W = $clog2(STEPS);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_3 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NONCE = 3'd4;

  // "expand 32-byte k" as little-endian words.
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic [63:0] key_0;
    logic [63:0] key_1;
    logic [63:0] key_2;
    logic [63:0] key_3;
    logic [63:0] nonce;
  } cfg_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  raw_count;
    logic [63:0] mask;
    logic        full;
    logic        start;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] counter;
  } core_req_t;

  // A count of eight or more keeps every byte; zero keeps none.
  function automatic logic [63:0] byte_mask(input logic [3:0] raw);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (raw > 4'(b)) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// File: design/cc20_front.sv
module cc20_front import cc20_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [4:0]  in_tuser,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  item_t             new_item;

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    new_item.data      = in_tdata;
    new_item.raw_count = in_tuser[3:0];
    new_item.mask      = byte_mask(in_tuser[3:0]);
    new_item.full      = in_tuser[3];
    new_item.start     = in_tuser[4];
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: design/cc20_core.sv
module cc20_core import cc20_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  core_req_t req,
  output logic      done,
  output block_t    ks
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_FF   = 3'b100
  } cstate_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // Fixed lane positions of the b, c and d words for column and diagonal rounds.
  localparam logic [3:0] B_COL  [4] = '{4'd4,  4'd5,  4'd6,  4'd7};
  localparam logic [3:0] C_COL  [4] = '{4'd8,  4'd9,  4'd10, 4'd11};
  localparam logic [3:0] D_COL  [4] = '{4'd12, 4'd13, 4'd14, 4'd15};
  localparam logic [3:0] B_DIAG [4] = '{4'd5,  4'd6,  4'd7,  4'd4};
  localparam logic [3:0] C_DIAG [4] = '{4'd10, 4'd11, 4'd8,  4'd9};
  localparam logic [3:0] D_DIAG [4] = '{4'd15, 4'd12, 4'd13, 4'd14};

  cstate_t           cstate_r, cstate_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  block_t            w_r, w_nxt;
  block_t            ks_r, ks_nxt;
  logic [63:0]       cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  block_t            init_start;
  block_t            init_ff;

  function automatic block_t make_init(input cfg_t c, input logic [63:0] counter);
    block_t s;
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    s[4]  = c.key_0[31:0];
    s[5]  = c.key_0[63:32];
    s[6]  = c.key_1[31:0];
    s[7]  = c.key_1[63:32];
    s[8]  = c.key_2[31:0];
    s[9]  = c.key_2[63:32];
    s[10] = c.key_3[31:0];
    s[11] = c.key_3[63:32];
    s[12] = counter[31:0];
    s[13] = counter[63:32];
    s[14] = c.nonce[31:0];
    s[15] = c.nonce[63:32];
    return s;
  endfunction

  // First half rotates by 16 and 12, second half by 8 and 7.
  function automatic quad_t qr_half(input quad_t q, input logic second);
    quad_t       r;
    logic [31:0] x;
    logic [31:0] y;
    r.a = q.a + q.b;
    x   = q.d ^ r.a;
    r.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
    r.c = q.c + r.d;
    y   = q.b ^ r.c;
    r.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
    return r;
  endfunction

  assign init_start = make_init(cfg, req.counter);
  assign init_ff    = make_init(cfg, cnt_r);
  assign done       = done_r;
  assign ks         = ks_r;

  always_comb begin
    quad_t qin;
    quad_t qout;
    logic  diag;
    cstate_nxt = cstate_r;
    step_nxt   = step_r;
    w_nxt      = w_r;
    ks_nxt     = ks_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    diag       = step_r[1];
    qin        = '0;
    qout       = '0;
    case (cstate_r)
      C_IDLE: begin
        if (req.start) begin
          w_nxt      = init_start;
          cnt_nxt    = req.counter;
          step_nxt   = '0;
          cstate_nxt = C_RUN;
        end
      end
      C_RUN: begin
        for (int i = 0; i < 4; i++) begin
          qin.a = w_r[i];
          qin.b = diag ? w_r[B_DIAG[i]] : w_r[B_COL[i]];
          qin.c = diag ? w_r[C_DIAG[i]] : w_r[C_COL[i]];
          qin.d = diag ? w_r[D_DIAG[i]] : w_r[D_COL[i]];
          qout  = qr_half(qin, step_r[0]);
          w_nxt[i] = qout.a;
          if (diag) begin
            w_nxt[B_DIAG[i]] = qout.b;
            w_nxt[C_DIAG[i]] = qout.c;
            w_nxt[D_DIAG[i]] = qout.d;
          end else begin
            w_nxt[B_COL[i]] = qout.b;
            w_nxt[C_COL[i]] = qout.c;
            w_nxt[D_COL[i]] = qout.d;
          end
        end
        if (step_r == STEP_W'(STEPS - 1)) begin
          cstate_nxt = C_FF;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      C_FF: begin
        for (int i = 0; i < 16; i++) begin
          ks_nxt[i] = w_r[i] + init_ff[i];
        end
        done_nxt   = 1'b1;
        cstate_nxt = C_IDLE;
      end
      default: begin
        cstate_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    ks_r  <= ks_nxt;
    cnt_r <= cnt_nxt;
    step_r <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cstate_r <= C_IDLE;
      done_r   <= 1'b0;
    end else begin
      cstate_r <= cstate_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

// File: design/cc20_back.sv
module cc20_back import cc20_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output core_req_t   core_req,
  input  logic        core_done,
  input  block_t      ks,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [3:0]  out_tuser
);

  typedef enum logic [1:0] {
    B_IDLE  = 2'b01,
    B_BUILD = 2'b10
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [63:0] counter_r, counter_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        kv_r, kv_nxt;
  item_t       cur_r, cur_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [3:0]  out_cnt_r, out_cnt_nxt;

  logic        take;
  logic [63:0] eff_counter;
  logic [2:0]  eff_pos;
  logic        eff_kv;
  logic        exec_go;
  item_t       exec_item;
  logic [2:0]  exec_pos;
  logic [63:0] exec_counter;
  logic [63:0] ks_word;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cnt_r;

  // The output register is free or drains this cycle, so it can take the result.
  assign take  = (state_r == B_IDLE) && q_valid && (!out_valid_r || out_tready);
  assign q_pop = take;

  assign eff_counter = q_item.start ? '0 : counter_r;
  assign eff_pos     = q_item.start ? '0 : pos_r;
  assign eff_kv      = q_item.start ? 1'b0 : kv_r;

  assign ks_word = {ks[{exec_pos, 1'b1}], ks[{exec_pos, 1'b0}]};

  always_comb begin
    state_nxt        = state_r;
    counter_nxt      = counter_r;
    pos_nxt          = pos_r;
    kv_nxt           = kv_r;
    cur_nxt          = cur_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    out_cnt_nxt      = out_cnt_r;
    core_req.start   = 1'b0;
    core_req.counter = eff_counter;
    exec_go          = 1'b0;
    exec_item        = q_item;
    exec_pos         = eff_pos;
    exec_counter     = eff_counter;

    case (state_r)
      B_IDLE: begin
        if (take) begin
          if (eff_kv) begin
            exec_go = 1'b1;
          end else begin
            core_req.start = 1'b1;
            cur_nxt        = q_item;
            counter_nxt    = eff_counter;
            pos_nxt        = eff_pos;
            kv_nxt         = 1'b0;
            state_nxt      = B_BUILD;
          end
        end
      end
      B_BUILD: begin
        if (core_done) begin
          exec_go      = 1'b1;
          exec_item    = cur_r;
          exec_pos     = pos_r;
          exec_counter = counter_r;
          state_nxt    = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (exec_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (exec_item.data ^ ks_word) & exec_item.mask;
      out_cnt_nxt   = exec_item.raw_count;
      if (exec_item.full) begin
        pos_nxt = exec_pos + 1'b1;
        if (exec_pos == 3'd7) begin
          counter_nxt = exec_counter + 1'b1;
          kv_nxt      = 1'b0;
        end else begin
          counter_nxt = exec_counter;
          kv_nxt      = 1'b1;
        end
      end else begin
        // A short word closes the message.
        counter_nxt = '0;
        pos_nxt     = '0;
        kv_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      counter_r   <= '0;
      pos_r       <= '0;
      kv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      counter_r   <= counter_nxt;
      pos_r       <= pos_nxt;
      kv_r        <= kv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/chacha20_stream_cipher.sv
// Channel   Direction  Handshake            Payload
// in_*      slave      in_tvalid/in_tready  tdata: data_in; tuser: byte_count, message_start
// out_*     master     out_tvalid/out_tready tdata: data_out; tuser: byte_count_out
// cfg_*     slave      cfg_valid/cfg_ready  cfg_addr: register index; cfg_data: value
//
// A word whose keystream block is already built gives its result in the cycle after it
// leaves the input queue. A word that needs a new block waits for the load, the rounds at
// one half quarter-round step of all four lanes per cycle, and the feed-forward add. One
// block serves eight words. Reset needs no clearing pass. A two-entry input queue and the
// output register let either side stall without stopping the other.
module chacha20_stream_cipher import cc20_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // [63:0] data_in
  input  logic [4:0]            in_tuser,   // [3:0] byte_count, [4] message_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,  // [63:0] data_out
  output logic [3:0]            out_tuser,  // [3:0] byte_count_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]           cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      q_valid;
  item_t     q_item;
  logic      q_pop;
  core_req_t core_req;
  logic      core_done;
  block_t    ks;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        REG_KEY_0: cfg_nxt.key_0 = cfg_data;
        REG_KEY_1: cfg_nxt.key_1 = cfg_data;
        REG_KEY_2: cfg_nxt.key_2 = cfg_data;
        REG_KEY_3: cfg_nxt.key_3 = cfg_data;
        REG_NONCE: cfg_nxt.nonce = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cc20_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  cc20_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .req   (core_req),
    .done  (core_done),
    .ks    (ks)
  );

  cc20_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .core_req   (core_req),
    .core_done  (core_done),
    .ks         (ks),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: design/cc20_checker.sv
module cc20_checker import cc20_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [3:0]  out_tuser
);

  logic [2:0]  inflight_r, inflight_nxt;
  logic        in_acc;
  logic        out_acc;
  logic [63:0] out_mask;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign out_mask = byte_mask(out_tuser);

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // Every result shown must belong to an item taken in and not yet answered.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != '0)
    else $error("result shown with no item outstanding");

  // Bytes beyond the valid count are always cleared.
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata & ~out_mask) == '0)
    else $error("invalid bytes of a result are not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind chacha20_stream_cipher cc20_checker u_checker (.*);

// File: tb/chacha20_stream_cipher_tb.sv
module chacha20_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cc20_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE       = 8;
  localparam int END_CYCLES   = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 245;
  localparam int MAX_PRINTED  = 40;
  localparam int SPARE_REGS   = (1 << CFG_ADDR_W) - 1 - int'(REG_NONCE);

  typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} key_fill_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
  } cipher_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;
  logic [4:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [63:0]           out_tdata;
  logic [3:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [63:0]           cfg_data = '0;

  // Shadow of the cipher: registers, block counter and the current keystream block.
  logic [63:0] cipher_key [4] = '{default: '0};
  logic [63:0] cipher_nonce = '0;
  logic [63:0] block_ctr = '0;
  logic [2:0]  word_idx = '0;
  logic        block_fresh = 1'b0;
  block_t      keystream = '0;

  cipher_word_t expected_words [$];

  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_request = 1'b0;

  int unsigned words_sent;
  int unsigned messages_sent;
  int unsigned blocks_made;
  int unsigned reg_writes;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned idle_cycles;

  chacha20_stream_cipher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [63:0] data_in
    .in_tuser   (in_tuser),   // [3:0] byte_count, [4] message_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [63:0] data_out
    .out_tuser  (out_tuser),  // [3:0] byte_count_out
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [63:0] random64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rotl32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic block_t quarter_round(block_t w, int a, int b, int c, int d);
    w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic block_t make_keystream(logic [63:0] ctr);
    block_t init;
    block_t w;
    init[0]  = SIGMA_0;
    init[1]  = SIGMA_1;
    init[2]  = SIGMA_2;
    init[3]  = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init[4 + 2 * k] = cipher_key[k][31:0];
      init[5 + 2 * k] = cipher_key[k][63:32];
    end
    init[12] = ctr[31:0];
    init[13] = ctr[63:32];
    init[14] = cipher_nonce[31:0];
    init[15] = cipher_nonce[63:32];
    w = init;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      w = quarter_round(w, 0, 4, 8, 12);
      w = quarter_round(w, 1, 5, 9, 13);
      w = quarter_round(w, 2, 6, 10, 14);
      w = quarter_round(w, 3, 7, 11, 15);
      w = quarter_round(w, 0, 5, 10, 15);
      w = quarter_round(w, 1, 6, 11, 12);
      w = quarter_round(w, 2, 7, 8, 13);
      w = quarter_round(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      w[i] = w[i] + init[i];
    end
    return w;
  endfunction

  // Advances the shadow cipher by one accepted item and returns what the block must send.
  function automatic cipher_word_t predict_word(logic [63:0] data, logic [3:0] raw,
                                                logic start);
    cipher_word_t r;
    logic [63:0]  pad;
    logic [63:0]  keep;
    int           n;
    if (start) begin
      block_ctr   = '0;
      word_idx    = '0;
      block_fresh = 1'b0;
    end
    if (!block_fresh) begin
      keystream   = make_keystream(block_ctr);
      block_fresh = 1'b1;
      blocks_made++;
    end
    pad  = {keystream[2 * word_idx + 1], keystream[2 * word_idx]};
    n    = (raw > 4'd8) ? 8 : int'(raw);
    keep = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    r.data  = (data ^ pad) & keep;
    r.count = raw;
    if (n == 8) begin
      word_idx = word_idx + 3'd1;
      if (word_idx == 3'd0) begin
        block_ctr   = block_ctr + 64'd1;
        block_fresh = 1'b0;
      end
    end else begin
      // A short word closes the message.
      block_ctr   = '0;
      word_idx    = '0;
      block_fresh = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("%0t: result %0d %s: got %h, expected %h", $realtime, results_seen, what,
               got, want);
    end
    error_count++;
  endtask

  task automatic send_word(logic [63:0] data, logic [3:0] count, logic start);
    int gap;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= {start, count};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    expected_words.push_back(predict_word(data, count, start));
    words_sent++;
  endtask

  task automatic send_message(int len, bit closed, bit with_start);
    logic [3:0] count;
    logic       start;
    for (int i = 0; i < len; i++) begin
      start = (i == 0) ? with_start : ($urandom_range(0, 32) == 0);
      if (i == len - 1 && closed) begin
        count = 4'($urandom_range(0, 7));
      end else if ($urandom_range(0, 9) == 0) begin
        count = 4'($urandom_range(9, 15));
      end else begin
        count = 4'd8;
      end
      send_word(random64(), count, start);
    end
    messages_sent++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_KEY_0: cipher_key[0] = val;
      REG_KEY_1: cipher_key[1] = val;
      REG_KEY_2: cipher_key[2] = val;
      REG_KEY_3: cipher_key[3] = val;
      REG_NONCE: cipher_nonce  = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Writes every register, then a few writes to unused indexes that must change nothing.
  task automatic program_config(key_fill_t fill, int n_spare);
    logic [63:0] v;
    for (int a = 0; a <= int'(REG_NONCE); a++) begin
      case (fill)
        FILL_ZERO: v = '0;
        FILL_ONES: v = '1;
        default:   v = random64();
      endcase
      write_reg(CFG_ADDR_W'(a), v);
    end
    for (int k = 0; k < n_spare; k++) begin
      write_reg(REG_NONCE + CFG_ADDR_W'(1 + k % SPARE_REGS), random64());
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Zero key from reset: extreme data, byte counts 0, 1, 2, 7 and 8 to 15, tails and restarts.
  task automatic test_edge_words();
    send_word('0, 4'd8, 1'b1);
    send_word('1, 4'd8, 1'b0);
    for (int c = 9; c <= 14; c++) begin
      send_word(random64(), 4'(c), 1'b0);
    end
    send_word(random64(), 4'd15, 1'b0);
    send_word(random64(), 4'd1, 1'b0);
    // The next two words start new messages without the start flag.
    send_word(random64(), 4'd0, 1'b0);
    send_word('1, 4'd7, 1'b0);
    send_word(random64(), 4'd8, 1'b1);
    send_word(random64(), 4'd8, 1'b0);
    send_word(random64(), 4'd8, 1'b1);
    send_word(random64(), 4'd2, 1'b0);
    messages_sent += 5;
    finish_phase();
  endtask

  task automatic test_register_extremes();
    program_config(FILL_ONES, SPARE_REGS);
    send_message(10, 1'b1, 1'b1);
    finish_phase();
    program_config(FILL_ZERO, 0);
    send_message(4, 1'b1, 1'b1);
    finish_phase();
  endtask

  // New key and nonce written while a block is in use apply from the next block on.
  task automatic test_rekey_mid_block();
    program_config(FILL_RANDOM, 0);
    send_word(random64(), 4'd8, 1'b1);
    send_word(random64(), 4'd8, 1'b0);
    send_word(random64(), 4'd8, 1'b0);
    finish_phase();
    write_reg(REG_KEY_2, random64());
    write_reg(REG_NONCE, random64());
    cfg_valid <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_word(random64(), 4'd8, 1'b0);
    end
    send_word(random64(), 4'd4, 1'b0);
    finish_phase();
    write_reg(REG_KEY_0, random64());
    cfg_valid <= 1'b0;
    send_word(random64(), 4'd8, 1'b1);
    send_word(random64(), 4'd6, 1'b0);
    messages_sent += 2;
    finish_phase();
  endtask

  task automatic test_output_backpressure();
    tx_gaps      = 1'b0;
    hold_request = 1'b1;
    send_message(24, 1'b1, 1'b1);
    finish_phase();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int  goal;
    int  len;
    bit  calm;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1) begin
        program_config(FILL_ONES, $urandom_range(0, 2));
      end else if (ph == 2) begin
        program_config(FILL_ZERO, $urandom_range(0, 2));
      end else begin
        program_config(FILL_RANDOM, $urandom_range(0, 2));
      end
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
        calm      = (ph == PHASES - 1) || ($urandom_range(0, 4) == 0);
        tx_gaps   = !calm;
        rx_stalls = !calm;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_message(len, $urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0);
      end
      finish_phase();
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected item", out_tdata, '0);
      end else begin
        if (out_tdata !== expected_words[0].data) begin
          report_mismatch("data_out", out_tdata, expected_words[0].data);
        end
        if (out_tuser !== expected_words[0].count) begin
          report_mismatch("byte_count_out", 64'(out_tuser), 64'(expected_words[0].count));
        end
        void'(expected_words.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[chacha20_stream_cipher] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_words();
    test_register_extremes();
    test_rekey_mid_block();
    test_output_backpressure();
    test_random_traffic();
    repeat (END_CYCLES) @(posedge clk);
    $display("Sent %0d words in %0d messages over %0d keystream blocks, %0d register writes.",
             words_sent, messages_sent, blocks_made, reg_writes);
    $display("Checked %0d results with %0d mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("[chacha20_stream_cipher] OK");
    end else begin
      $display("[chacha20_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
